// File: rtl/core/tewg_pkg.sv
// ----------------------------------------------------------------------------
// tewg_pkg: shared types and constants for the timer event window group
// payload structs, sequencer states, status codes and reset values
// ----------------------------------------------------------------------------
package tewg_pkg;

   // default table size and register reset value
   localparam int          SLOT_COUNT_DEF  = 16;
   localparam logic [31:0] MIN_OVERLAP_RST = 32'd500;

   // request kinds
   localparam logic KIND_ADD = 1'b0;
   localparam logic KIND_DEL = 1'b1;

   // result status codes
   localparam logic [2:0] STATUS_OK         = 3'd0;
   localparam logic [2:0] STATUS_NO_OVERLAP = 3'd1;
   localparam logic [2:0] STATUS_TOO_NARROW = 3'd2;
   localparam logic [2:0] STATUS_FULL       = 3'd3;
   localparam logic [2:0] STATUS_NOT_LIVE   = 3'd4;

   // sequencer states
   typedef enum logic [2:0] {
      S_IDLE,
      S_CHECK,
      S_NARROW,
      S_FIND,
      S_DEL,
      S_WALK,
      S_FINISH
   } state_type;

   // one firing window, start and end bounds
   typedef struct packed {
      logic [63:0] win_start;
      logic [63:0] win_end;
   } window_type;

   // input request payload
   typedef struct packed {
      logic        kind;
      logic [63:0] trigger_time;
      logic [31:0] allowed_delay;
      logic [3:0]  slot_index;
   } req_type;

   // result payload
   typedef struct packed {
      logic [2:0]  status;
      logic [3:0]  assigned_slot;
      logic [63:0] window_start;
      logic [63:0] window_end;
      logic        group_empty;
   } rsp_type;

endpackage

// File: rtl/core/tewg_ram.sv
// ----------------------------------------------------------------------------
// tewg_ram: generic single write port ram
// one write and one read address per cycle, registered read data
// ----------------------------------------------------------------------------
module tewg_ram #(
   parameter int WIDTH = 128,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// File: rtl/core/tewg_win_unit.sv
// ----------------------------------------------------------------------------
// tewg_win_unit: shared window compare unit
// intersects an item window with the running window and flags disjoint pairs
// ----------------------------------------------------------------------------
module tewg_win_unit (
   input  tewg_pkg::window_type item,
   input  tewg_pkg::window_type acc,
   output tewg_pkg::window_type narrowed,
   output logic                 disjoint
);
   import tewg_pkg::*;

   // intersection: later start, earlier end
   always_comb begin
      narrowed.win_start = (item.win_start > acc.win_start) ? item.win_start : acc.win_start;
      narrowed.win_end   = (item.win_end < acc.win_end) ? item.win_end : acc.win_end;
   end

   // item starts at or past the end, or ends at or before the start
   assign disjoint = (item.win_start >= acc.win_end) || (item.win_end <= acc.win_start);

endmodule

// File: rtl/core/timer_event_window_group_core.sv
// ----------------------------------------------------------------------------
// timer_event_window_group_core: timer trigger window grouping engine
// keeps a slot table of trigger windows and their common intersection
// ----------------------------------------------------------------------------
//
// channel   | direction | handshake          | payload
// ----------+-----------+--------------------+--------------------------
// req       | in        | req_valid/req_stall| tewg_pkg::req_type
// rsp       | out       | rsp_valid/rsp_stall| tewg_pkg::rsp_type
// csr       | in        | csr_valid/csr_ready| min_overlap, 32 bit
//
// a request is taken only in the idle state; an add into an empty group, a
// disjoint add or a dead delete goes on to the finish state, a narrow add after
// the width check, a stored add after a scan of at most used_count + 1 slots,
// and a live delete after a walk over the slots below the used count
// the delete walk reads one slot per cycle from the slot ram; req_stall is high
// until the result is loaded into the output register, which waits for an empty
// register or low rsp_stall; sync reset clears live bits and counters, no clearing pass
//
module timer_event_window_group_core #(
   parameter int SLOT_COUNT = tewg_pkg::SLOT_COUNT_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  tewg_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output tewg_pkg::rsp_type rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [31:0]       csr_data
);
   import tewg_pkg::*;

   localparam int SLOT_W = $clog2(SLOT_COUNT);
   localparam int CNT_W  = $clog2(SLOT_COUNT + 1);

   // sequencer and request registers
   state_type           state_ff, state_in;
   window_type          win_ff, win_in;
   logic [3:0]          idx_ff, idx_in;
   window_type          acc_ff, acc_in;
   window_type          com_ff, com_in;
   logic [2:0]          status_ff, status_in;
   logic [SLOT_W-1:0]   slot_ff, slot_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [CNT_W-1:0]    used_ff, used_in;
   logic [CNT_W-1:0]    live_cnt_ff, live_cnt_in;
   logic [SLOT_COUNT-1:0] live_ff, live_in;
   logic [31:0]         min_ovl_ff;
   logic                pend_ff, pend_in;
   logic                seeded_ff, seeded_in;
   logic                rsp_valid_ff;
   rsp_type             rsp_ff;

   // slot ram and shared unit
   logic                ram_we;
   logic [SLOT_W-1:0]   ram_waddr;
   logic [SLOT_W-1:0]   ram_raddr;
   window_type          ram_wdata;
   window_type          ram_rdata;
   window_type          unit_item;
   window_type          unit_acc;
   window_type          unit_out;
   logic                unit_disjoint;

   // decoded conditions
   logic                req_fire;
   logic                out_free;
   logic [64:0]         end_sum;
   logic [63:0]         end_sat;
   logic [SLOT_W-1:0]   scan_slot;
   logic                scan_in_range;
   logic                table_full;
   logic [63:0]         width_diff;
   logic                too_narrow;
   logic [SLOT_W-1:0]   del_slot;
   logic                del_ok;
   logic                del_is_top;
   logic                group_empty;

   assign req_stall = (state_ff != S_IDLE);
   assign req_fire  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign csr_ready = (state_ff == S_IDLE);

   // saturating window end of an incoming add
   assign end_sum = 65'(req_data.trigger_time) + 65'(req_data.allowed_delay);
   assign end_sat = end_sum[64] ? '1 : end_sum[63:0];

   assign scan_slot     = cnt_ff[SLOT_W-1:0];
   assign scan_in_range = (cnt_ff < used_ff);
   assign table_full    = (used_ff == CNT_W'(SLOT_COUNT));
   assign width_diff    = acc_ff.win_end - acc_ff.win_start;
   assign too_narrow    = (width_diff <= 64'(min_ovl_ff));
   assign del_slot      = SLOT_W'(idx_ff);
   assign del_ok        = (32'(idx_ff) < 32'(SLOT_COUNT)) && live_ff[del_slot];
   assign del_is_top    = ((CNT_W'(idx_ff) + CNT_W'(1)) == used_ff);
   assign group_empty   = (live_cnt_ff == '0);

   // slot table storage
   tewg_ram #(
      .WIDTH ($bits(window_type)),
      .DEPTH (SLOT_COUNT)
   ) u_slot_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   // shared intersect unit: new add against group, or walk against running window
   always_comb begin
      if (state_ff == S_WALK) begin
         unit_item = ram_rdata;
         unit_acc  = acc_ff;
      end else begin
         unit_item = win_ff;
         unit_acc  = com_ff;
      end
   end

   tewg_win_unit u_win_unit (
      .item     (unit_item),
      .acc      (unit_acc),
      .narrowed (unit_out),
      .disjoint (unit_disjoint)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               state_in = (req_data.kind == KIND_ADD) ? S_CHECK : S_DEL;
            end
         end
         S_CHECK: begin
            if (group_empty || unit_disjoint) begin
               state_in = S_FINISH;
            end else begin
               state_in = S_NARROW;
            end
         end
         S_NARROW: begin
            state_in = too_narrow ? S_FINISH : S_FIND;
         end
         S_FIND: begin
            if (!scan_in_range || !live_ff[scan_slot]) begin
               state_in = S_FINISH;
            end
         end
         S_DEL: begin
            state_in = del_ok ? S_WALK : S_FINISH;
         end
         S_WALK: begin
            if (!scan_in_range && !pend_ff) begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // datapath controls and register next values
   always_comb begin
      win_in      = win_ff;
      idx_in      = idx_ff;
      acc_in      = acc_ff;
      com_in      = com_ff;
      status_in   = status_ff;
      slot_in     = slot_ff;
      cnt_in      = cnt_ff;
      used_in     = used_ff;
      live_cnt_in = live_cnt_ff;
      live_in     = live_ff;
      pend_in     = pend_ff;
      seeded_in   = seeded_ff;
      ram_we      = 1'b0;
      ram_waddr   = scan_slot;
      ram_wdata   = win_ff;
      ram_raddr   = scan_slot;
      case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               win_in.win_start = req_data.trigger_time;
               win_in.win_end   = end_sat;
               idx_in           = req_data.slot_index;
               status_in        = STATUS_OK;
               slot_in          = '0;
            end
         end
         S_CHECK: begin
            if (group_empty) begin
               // first trigger of a group takes slot 0
               ram_we      = 1'b1;
               ram_waddr   = '0;
               live_in[0]  = 1'b1;
               used_in     = CNT_W'(1);
               live_cnt_in = CNT_W'(1);
               com_in      = win_ff;
            end else if (unit_disjoint) begin
               status_in = STATUS_NO_OVERLAP;
            end else begin
               acc_in = unit_out;
               cnt_in = '0;
            end
         end
         S_NARROW: begin
            if (too_narrow) begin
               status_in = STATUS_TOO_NARROW;
            end
         end
         S_FIND: begin
            // first dead slot below the used count, else append
            if (scan_in_range && live_ff[scan_slot]) begin
               cnt_in = cnt_ff + CNT_W'(1);
            end else if (!scan_in_range && table_full) begin
               status_in = STATUS_FULL;
            end else begin
               ram_we             = 1'b1;
               live_in[scan_slot] = 1'b1;
               live_cnt_in        = live_cnt_ff + CNT_W'(1);
               com_in             = acc_ff;
               slot_in            = scan_slot;
               if (!scan_in_range) begin
                  used_in = used_ff + CNT_W'(1);
               end
            end
         end
         S_DEL: begin
            if (del_ok) begin
               live_in[del_slot] = 1'b0;
               live_cnt_in       = live_cnt_ff - CNT_W'(1);
               if (del_is_top) begin
                  used_in = used_ff - CNT_W'(1);
               end
               cnt_in    = '0;
               pend_in   = 1'b0;
               seeded_in = 1'b0;
            end else begin
               status_in = STATUS_NOT_LIVE;
            end
         end
         S_WALK: begin
            // issue one slot read per cycle, fold the returned window in the cycle after
            pend_in = scan_in_range && live_ff[scan_slot];
            if (scan_in_range) begin
               cnt_in = cnt_ff + CNT_W'(1);
            end
            if (pend_ff) begin
               seeded_in = 1'b1;
               acc_in    = seeded_ff ? unit_out : ram_rdata;
            end
            if (!scan_in_range && !pend_ff) begin
               if (seeded_ff) begin
                  com_in = acc_ff;
               end else begin
                  used_in = '0;
                  com_in  = '0;
               end
            end
         end
         S_FINISH: begin
         end
         default: begin
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         cnt_ff      <= '0;
         used_ff     <= '0;
         live_cnt_ff <= '0;
         live_ff     <= '0;
         com_ff      <= '0;
         pend_ff     <= 1'b0;
         seeded_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         cnt_ff      <= cnt_in;
         used_ff     <= used_in;
         live_cnt_ff <= live_cnt_in;
         live_ff     <= live_in;
         com_ff      <= com_in;
         pend_ff     <= pend_in;
         seeded_ff   <= seeded_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      win_ff    <= win_in;
      idx_ff    <= idx_in;
      acc_ff    <= acc_in;
      status_ff <= status_in;
      slot_ff   <= slot_in;
   end

   // min overlap register
   always_ff @(posedge clock) begin
      if (reset) begin
         min_ovl_ff <= MIN_OVERLAP_RST;
      end else if (csr_valid && csr_ready) begin
         min_ovl_ff <= csr_data;
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if ((state_ff == S_FINISH) && out_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((state_ff == S_FINISH) && out_free) begin
         rsp_ff.status        <= status_ff;
         rsp_ff.assigned_slot <= 4'(slot_ff);
         rsp_ff.window_start  <= com_ff.win_start;
         rsp_ff.window_end    <= com_ff.win_end;
         rsp_ff.group_empty   <= group_empty;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // live count tracks the live bits
   a_live_count: assert property (@(posedge clock) disable iff (reset)
      $countones(live_ff) == int'(live_cnt_ff))
      else $error("live count out of step with live bits");

   // live slot count never exceeds the used count
   a_live_below_used: assert property (@(posedge clock) disable iff (reset)
      live_cnt_ff <= used_ff)
      else $error("more live slots than used slots");

   // slot search only runs on a non-empty group
   a_find_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIND) |-> (live_cnt_ff != '0))
      else $error("slot search on an empty group");

   // a finished request always lands in the output register
   a_finish_emits: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == S_FINISH) && out_free) |=> rsp_valid_ff)
      else $error("finished request not presented");

endmodule
